// ===== hw/rtl/mtrp_pkg.sv =====
// Shared types and constants of the Modbus TCP request parser.
`default_nettype none

package mtrp_pkg;

    // Largest register count a request may ask for.
    localparam int REG_CAPACITY = 128;
    localparam int WORDS_W      = 8;
    localparam int WORD_IDX_W   = 7;

    // Result buffer depth; the parser needs room for two results per byte.
    localparam int RES_DEPTH    = 4;
    localparam int RES_PTR_W    = 2;
    localparam int RES_CNT_W    = 3;

    localparam logic [15:0] MAX_START_RESET = 16'd1023;
    localparam logic [7:0]  FN_READ_MULTI   = 8'd3;
    localparam logic [7:0]  FN_WRITE_MULTI  = 8'd16;
    localparam logic [15:0] PROTOCOL_MODBUS = 16'd0;

    typedef enum logic [3:0] {
        POS_TRANS_HI = 4'd0,
        POS_TRANS_LO = 4'd1,
        POS_PROTO_HI = 4'd2,
        POS_PROTO_LO = 4'd3,
        POS_LEN_HI   = 4'd4,
        POS_LEN_LO   = 4'd5,
        POS_UNIT     = 4'd6,
        POS_FUNC     = 4'd7,
        POS_START_HI = 4'd8,
        POS_START_LO = 4'd9,
        POS_COUNT_HI = 4'd10,
        POS_COUNT_LO = 4'd11,
        POS_BYTE_CNT = 4'd12,
        POS_DATA     = 4'd13
    } t_pos;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_PROTOCOL = 3'd1,
        ST_BAD_FUNCTION = 3'd2,
        ST_BAD_ADDRESS  = 3'd3,
        ST_INCOMPLETE   = 3'd4,
        ST_TOO_MANY     = 3'd5
    } t_status;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_frame;
        logic       end_of_burst;
    } t_in_item;

    typedef struct packed {
        t_kind                   result_kind;
        t_status                 status;
        logic [15:0]             transaction_id;
        logic [7:0]              unit_id;
        logic [7:0]              function_code;
        logic [15:0]             start_address;
        logic [15:0]             register_count;
        logic [15:0]             length_field;
        logic [WORD_IDX_W-1:0]   word_index;
        logic [15:0]             word_value;
        logic                    last;
    } t_result;

    // Results of one byte, handed from the parser to the result buffer.
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_res_pair;

endpackage

`default_nettype wire

// ===== hw/rtl/mtrp_ifs.sv =====
// Valid/ready channel interfaces for request bytes and parser results.
`default_nettype none

interface mtrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_frame;
    logic       end_of_burst;

    modport source (output valid, output data_byte, output start_of_frame,
                    output end_of_burst, input ready);
    modport sink   (input valid, input data_byte, input start_of_frame,
                    input end_of_burst, output ready);
endinterface

interface mtrp_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [2:0]  status;
    logic [15:0] transaction_id;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] register_count;
    logic [15:0] length_field;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic        last;

    modport source (output valid, output result_kind, output status,
                    output transaction_id, output unit_id, output function_code,
                    output start_address, output register_count,
                    output length_field, output word_index, output word_value,
                    output last, input ready);
    modport sink   (input valid, input result_kind, input status,
                    input transaction_id, input unit_id, input function_code,
                    input start_address, input register_count,
                    input length_field, input word_index, input word_value,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mtrp_in_reg.sv =====
// Input register: holds one accepted byte until the parser consumes it.
`default_nettype none

module mtrp_in_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mtrp_in_if.sink           i_in,
    input  wire               i_take,
    output logic              o_valid,
    output mtrp_pkg::t_in_item o_item
);

    logic               r_valid;
    mtrp_pkg::t_in_item r_item;
    logic               accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte      <= i_in.data_byte;
            r_item.start_of_frame <= i_in.start_of_frame;
            r_item.end_of_burst   <= i_in.end_of_burst;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/mtrp_step.sv =====
// Frame parser: header/PDU state and the results caused by one byte.
`default_nettype none

module mtrp_step (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  mtrp_pkg::t_in_item  i_item,
    input  wire  [15:0]         i_max_start,
    output mtrp_pkg::t_res_pair o_pair
);

    mtrp_pkg::t_pos       r_pos, n_pos, pos;
    logic [15:0]          r_trans, n_trans;
    logic [15:0]          r_proto, n_proto;
    logic [15:0]          r_len, n_len;
    logic [7:0]           r_unit, n_unit;
    logic [7:0]           r_func, n_func;
    logic [15:0]          r_start, n_start;
    logic [15:0]          r_count, n_count;
    logic [8:0]           r_pend, n_pend;
    logic [mtrp_pkg::WORDS_W-1:0] r_words, n_words;

    logic                 done;
    mtrp_pkg::t_status    st;
    logic                 word_emit;
    logic [15:0]          word_val;
    logic [mtrp_pkg::WORD_IDX_W-1:0] word_idx;
    logic                 status_emit;
    mtrp_pkg::t_status    status_code;
    mtrp_pkg::t_result    word_res, stat_res;
    logic [7:0]           b;

    assign b = i_item.data_byte;

    always_comb begin
        pos = r_pos;
        if (i_item.start_of_frame || (r_pos > mtrp_pkg::POS_DATA)) begin
            pos = mtrp_pkg::POS_TRANS_HI;
        end
        n_pos = pos;
        // First header byte starts a fresh frame.
        if (pos == mtrp_pkg::POS_TRANS_HI) begin
            n_trans = '0; n_proto = '0; n_len = '0; n_unit = '0; n_func = '0;
            n_start = '0; n_count = '0; n_pend = '0; n_words = '0;
        end else begin
            n_trans = r_trans; n_proto = r_proto; n_len = r_len;
            n_unit = r_unit; n_func = r_func; n_start = r_start;
            n_count = r_count; n_pend = r_pend; n_words = r_words;
        end
        done      = 1'b0;
        st        = mtrp_pkg::ST_OK;
        word_emit = 1'b0;
        word_val  = {n_pend[7:0], b};
        word_idx  = n_words[mtrp_pkg::WORD_IDX_W-1:0];

        unique case (pos)
            mtrp_pkg::POS_TRANS_HI: begin
                n_trans = {b, 8'd0};
                n_pos   = mtrp_pkg::POS_TRANS_LO;
            end
            mtrp_pkg::POS_TRANS_LO: begin
                n_trans = {n_trans[15:8], b};
                n_pos   = mtrp_pkg::POS_PROTO_HI;
            end
            mtrp_pkg::POS_PROTO_HI: begin
                n_proto = {b, 8'd0};
                n_pos   = mtrp_pkg::POS_PROTO_LO;
            end
            mtrp_pkg::POS_PROTO_LO: begin
                n_proto = {n_proto[15:8], b};
                if (n_proto != mtrp_pkg::PROTOCOL_MODBUS) begin
                    done = 1'b1;
                    st   = mtrp_pkg::ST_BAD_PROTOCOL;
                end else begin
                    n_pos = mtrp_pkg::POS_LEN_HI;
                end
            end
            mtrp_pkg::POS_LEN_HI: begin
                n_len = {b, 8'd0};
                n_pos = mtrp_pkg::POS_LEN_LO;
            end
            mtrp_pkg::POS_LEN_LO: begin
                n_len = {n_len[15:8], b};
                n_pos = mtrp_pkg::POS_UNIT;
            end
            mtrp_pkg::POS_UNIT: begin
                n_unit = b;
                n_pos  = mtrp_pkg::POS_FUNC;
            end
            mtrp_pkg::POS_FUNC: begin
                n_func = b;
                if (b != mtrp_pkg::FN_READ_MULTI && b != mtrp_pkg::FN_WRITE_MULTI) begin
                    done = 1'b1;
                    st   = mtrp_pkg::ST_BAD_FUNCTION;
                end else begin
                    n_pos = mtrp_pkg::POS_START_HI;
                end
            end
            mtrp_pkg::POS_START_HI: begin
                n_start = {b, 8'd0};
                n_pos   = mtrp_pkg::POS_START_LO;
            end
            mtrp_pkg::POS_START_LO: begin
                n_start = {n_start[15:8], b};
                if (n_start > i_max_start) begin
                    done = 1'b1;
                    st   = mtrp_pkg::ST_BAD_ADDRESS;
                end else begin
                    n_pos = mtrp_pkg::POS_COUNT_HI;
                end
            end
            mtrp_pkg::POS_COUNT_HI: begin
                n_count = {b, 8'd0};
                n_pos   = mtrp_pkg::POS_COUNT_LO;
            end
            mtrp_pkg::POS_COUNT_LO: begin
                n_count = {n_count[15:8], b};
                if (n_count > 16'(mtrp_pkg::REG_CAPACITY)) begin
                    done = 1'b1;
                    st   = mtrp_pkg::ST_TOO_MANY;
                end else if (n_func == mtrp_pkg::FN_READ_MULTI) begin
                    done = 1'b1;
                end else begin
                    n_pos = mtrp_pkg::POS_BYTE_CNT;
                end
            end
            mtrp_pkg::POS_BYTE_CNT: begin
                // Byte count is skipped; a zero-register write ends here.
                if (n_count == 16'd0) begin
                    done = 1'b1;
                end else begin
                    n_pos = mtrp_pkg::POS_DATA;
                end
            end
            default: begin
                if (!n_pend[8]) begin
                    n_pend = {1'b1, b};
                end else begin
                    word_emit = 1'b1;
                    n_pend    = '0;
                    n_words   = n_words + 1'b1;
                    if (16'(n_words) >= n_count) begin
                        done = 1'b1;
                    end
                end
            end
        endcase

        status_emit = done || i_item.end_of_burst;
        status_code = done ? st : mtrp_pkg::ST_INCOMPLETE;

        word_res.result_kind    = mtrp_pkg::KIND_WORD;
        word_res.status         = mtrp_pkg::ST_OK;
        word_res.transaction_id = n_trans;
        word_res.unit_id        = n_unit;
        word_res.function_code  = n_func;
        word_res.start_address  = n_start;
        word_res.register_count = n_count;
        word_res.length_field   = n_len;
        word_res.word_index     = word_idx;
        word_res.word_value     = word_val;
        word_res.last           = !status_emit;

        stat_res                = word_res;
        stat_res.result_kind    = mtrp_pkg::KIND_STATUS;
        stat_res.status         = status_code;
        stat_res.word_index     = '0;
        stat_res.word_value     = '0;
        stat_res.last           = 1'b1;

        o_pair.num  = {1'b0, word_emit} + {1'b0, status_emit};
        o_pair.res0 = word_emit ? word_res : stat_res;
        o_pair.res1 = stat_res;

        // Finished or failed frame: restart the parser.
        if (done) begin
            n_pos = mtrp_pkg::POS_TRANS_HI;
            n_trans = '0; n_proto = '0; n_len = '0; n_unit = '0; n_func = '0;
            n_start = '0; n_count = '0; n_pend = '0; n_words = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= mtrp_pkg::POS_TRANS_HI;
            r_trans <= '0;
            r_proto <= '0;
            r_len   <= '0;
            r_unit  <= '0;
            r_func  <= '0;
            r_start <= '0;
            r_count <= '0;
            r_pend  <= '0;
            r_words <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_trans <= n_trans;
            r_proto <= n_proto;
            r_len   <= n_len;
            r_unit  <= n_unit;
            r_func  <= n_func;
            r_start <= n_start;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_words <= n_words;
        end
    end

    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && done) |=> (r_pos == mtrp_pkg::POS_TRANS_HI && r_pend == 9'd0))
        else $error("parser did not restart after a finished frame");

    a_word_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && word_emit) |-> (r_pos == mtrp_pkg::POS_DATA && r_pend[8]))
        else $error("register word emitted outside the write payload");

endmodule

`default_nettype wire

// ===== hw/rtl/mtrp_res_fifo.sv =====
// Result buffer: takes up to two results per byte, drains one per cycle while the output is ready.
`default_nettype none

module mtrp_res_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  mtrp_pkg::t_res_pair i_pair,
    output logic                o_room,
    mtrp_out_if.source          o_out
);

    mtrp_pkg::t_result                r_mem [mtrp_pkg::RES_DEPTH];
    logic [mtrp_pkg::RES_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [mtrp_pkg::RES_PTR_W-1:0]   r_rd_ptr;
    logic [mtrp_pkg::RES_CNT_W-1:0]   r_cnt, n_cnt;
    logic [mtrp_pkg::RES_PTR_W-1:0]   wr_ptr1;
    logic [1:0]                       push_num;
    logic                             pop;
    mtrp_pkg::t_result                head;

    // Room for two results regardless of this cycle's pop.
    assign o_room   = (r_cnt <= mtrp_pkg::RES_CNT_W'(mtrp_pkg::RES_DEPTH - 2));
    assign push_num = i_push ? i_pair.num : 2'd0;
    assign pop      = o_out.valid && o_out.ready;
    assign wr_ptr1  = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + mtrp_pkg::RES_PTR_W'(push_num);
        n_cnt    = r_cnt + mtrp_pkg::RES_CNT_W'(push_num)
                   - mtrp_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_cnt    <= n_cnt;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_pair.res0;
        end
        if (push_num == 2'd2) begin
            r_mem[wr_ptr1] <= i_pair.res1;
        end
    end

    assign head                 = r_mem[r_rd_ptr];
    assign o_out.valid          = (r_cnt != '0);
    assign o_out.result_kind    = head.result_kind;
    assign o_out.status         = head.status;
    assign o_out.transaction_id = head.transaction_id;
    assign o_out.unit_id        = head.unit_id;
    assign o_out.function_code  = head.function_code;
    assign o_out.start_address  = head.start_address;
    assign o_out.register_count = head.register_count;
    assign o_out.length_field   = head.length_field;
    assign o_out.word_index     = head.word_index;
    assign o_out.word_value     = head.word_value;
    assign o_out.last           = head.last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt + mtrp_pkg::RES_CNT_W'(i_pair.num)
                    <= mtrp_pkg::RES_CNT_W'(mtrp_pkg::RES_DEPTH)))
        else $error("result buffer overflow");

    a_pair_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_pair.num == 2'd2) |-> (i_pair.res1.last && !i_pair.res0.last))
        else $error("two results of one byte not ended by last");

endmodule

`default_nettype wire

// ===== hw/rtl/modbus_tcp_request_parser_unit.sv =====
// Top level of the Modbus TCP request parser.
//
//  Channel   Dir  Payload                                  Handshake
//  i_in      in   data_byte, start_of_frame, end_of_burst  valid/ready
//  o_out     out  one word or frame status result          valid/ready
//  i_cfg_*   in   max_start_address (16 bits)              write enable
//
// An accepted byte is held in the input register and parsed when it is taken;
// its results enter the result buffer and leave it one per cycle while o_out.ready is high.
// One byte is taken per cycle while the four-entry result buffer has room
// for two results; a byte that yields two results needs two output transfers.
// Synchronous active-low reset clears the parser to the first header byte
// and sets the address limit to 1023.
// A stalled output fills the buffer and then holds i_in.ready low.
`default_nettype none

module modbus_tcp_request_parser_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mtrp_in_if.sink    i_in,
    mtrp_out_if.source o_out,
    input  wire        i_cfg_wr_en,
    input  wire [15:0] i_cfg_wr_data
);

    logic                r_max_start;
    logic [15:0]         r_max_start_addr;
    logic                item_valid;
    mtrp_pkg::t_in_item  item;
    logic                room;
    logic                take;
    mtrp_pkg::t_res_pair pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_start_addr <= mtrp_pkg::MAX_START_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_start_addr <= i_cfg_wr_data;
        end
    end

    // Track whether the limit was ever written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_start <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_max_start <= 1'b1;
        end
    end

    assign take = item_valid && room;

    mtrp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    mtrp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (item),
        .i_max_start (r_max_start_addr),
        .o_pair      (pair)
    );

    mtrp_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_pair  (pair),
        .o_room  (room),
        .o_out   (o_out)
    );

    a_limit_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_max_start |-> (r_max_start_addr == mtrp_pkg::MAX_START_RESET))
        else $error("address limit changed without a write");

endmodule

`default_nettype wire
